// ===== rtl/fkd_pkg.sv =====
package fkd_pkg;

    localparam int CHAR_W = 8;
    localparam int LEN_W  = 16;
    localparam int DUR_W  = 20;
    localparam int PAT_W  = 6;
    localparam int IDX_W  = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam int OUT_TDATA_W = 24;

    localparam logic [IDX_W-1:0] REG_KEYING_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FSK_DIT       = 3'd1;
    localparam logic [IDX_W-1:0] REG_FSK_DAH       = 3'd2;
    localparam logic [IDX_W-1:0] REG_DFCW_QUARTER  = 3'd3;
    localparam logic [IDX_W-1:0] REG_DFCW_CHAR_GAP = 3'd4;

    localparam logic [LEN_W-1:0] RST_FSK_DIT       = 16'd100;
    localparam logic [LEN_W-1:0] RST_FSK_DAH       = 16'd300;
    localparam logic [LEN_W-1:0] RST_DFCW_QUARTER  = 16'd250;
    localparam logic [LEN_W-1:0] RST_DFCW_CHAR_GAP = 16'd1000;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BAR   = 8'h7C;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

    typedef enum logic [1:0] {
        CAR_OFF   = 2'd0,
        CAR_SPACE = 2'd1,
        CAR_MARK  = 2'd2,
        CAR_HOLD  = 2'd3
    } carrier_t;

    typedef enum logic [1:0] {
        JOB_PATTERN = 2'd0,
        JOB_SPACE   = 2'd1,
        JOB_BAR     = 2'd2,
        JOB_UNDER   = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t          kind;
        logic [PAT_W-1:0]   pattern;
    } job_t;

    typedef struct packed {
        logic               dfcw;
        logic [LEN_W-1:0]   dit;
        logic [LEN_W-1:0]   dah;
        logic [LEN_W-1:0]   qtr;
        logic [LEN_W-1:0]   char_gap;
    } keycfg_t;

    typedef struct packed {
        carrier_t           carrier;
        logic               mark_led;
        logic [DUR_W-1:0]   duration;
        logic               last;
    } seg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_SEP,
        ST_END,
        ST_GAP
    } back_state_t;

    function automatic logic [PAT_W-1:0] morse_pattern(input logic [CHAR_W-1:0] ch);
        logic [PAT_W-1:0] p;
        unique case (ch)
            8'h2F:   p = 6'd41;
            8'h41:   p = 6'd6;
            8'h42:   p = 6'd17;
            8'h43:   p = 6'd21;
            8'h44:   p = 6'd9;
            8'h47:   p = 6'd11;
            8'h4C:   p = 6'd18;
            8'h4D:   p = 6'd7;
            8'h4E:   p = 6'd5;
            8'h53:   p = 6'd8;
            8'h54:   p = 6'd3;
            8'h55:   p = 6'd12;
            8'h56:   p = 6'd24;
            8'h57:   p = 6'd14;
            8'h37:   p = 6'd35;
            8'h30:   p = 6'd63;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/fkd_front.sv =====
module fkd_front
    import fkd_pkg::*;
(
    input  logic              s_tvalid,
    input  logic [CHAR_W-1:0] s_tdata,
    output logic              s_tready,
    input  logic              q_full,
    output logic              q_push,
    output job_t              q_job
);

    logic [PAT_W-1:0] pattern;
    logic             known;

    assign pattern  = morse_pattern(s_tdata);
    assign s_tready = !q_full;

    always_comb
    begin
        q_job.pattern = pattern;
        known         = 1'b1;
        unique case (s_tdata)
            CH_SPACE: q_job.kind = JOB_SPACE;
            CH_BAR:   q_job.kind = JOB_BAR;
            CH_UNDER: q_job.kind = JOB_UNDER;
            default:
            begin
                q_job.kind = JOB_PATTERN;
                known      = (pattern != '0);
            end
        endcase
    end

    // drop unknown characters
    assign q_push = s_tvalid && s_tready && known;

endmodule

// ===== rtl/fkd_queue.sv =====
module fkd_queue
    import fkd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/fkd_back.sv =====
module fkd_back
    import fkd_pkg::*;
#(
    parameter int MAX_ELEMENTS = 5
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  keycfg_t cfg,
    input  logic    q_empty,
    input  job_t    q_job,
    output logic    q_pop,
    output logic    m_valid,
    output seg_t    m_seg,
    input  logic    m_ready
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_ELEMENTS - 1);

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [PAT_W-1:0] pat_reg;
    logic [PAT_W-1:0] pat_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    job_kind_t        kind_reg;
    job_kind_t        kind_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    seg_t             out_seg_reg;
    seg_t             out_seg_next;

    logic             adv;
    logic             seg_valid;
    seg_t             seg;
    logic [DUR_W-1:0] dit_w;
    logic [DUR_W-1:0] dah_w;
    logic [DUR_W-1:0] qtr_w;
    logic [DUR_W-1:0] gap_w;

    assign adv   = !out_valid_reg || m_ready;
    assign dit_w = DUR_W'(cfg.dit);
    assign dah_w = DUR_W'(cfg.dah);
    assign qtr_w = DUR_W'(cfg.qtr);
    assign gap_w = DUR_W'(cfg.char_gap);

    always_comb
    begin
        state_next = state_reg;
        pat_next   = pat_reg;
        cnt_next   = cnt_reg;
        kind_next  = kind_reg;
        q_pop      = 1'b0;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    pat_next  = q_job.pattern;
                    kind_next = q_job.kind;
                    cnt_next  = '0;
                    if (q_job.kind != JOB_PATTERN)
                    begin
                        state_next = ST_GAP;
                    end
                    else if (q_job.pattern > PAT_W'(1))
                    begin
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_MARK:
            begin
                if (adv)
                begin
                    state_next = ST_SEP;
                end
            end
            ST_SEP:
            begin
                if (adv)
                begin
                    pat_next = pat_reg >> 1;
                    cnt_next = cnt_reg + 1'b1;
                    if ((pat_reg[PAT_W-1:1] > (PAT_W-1)'(1)) && (cnt_reg != CNT_LAST))
                    begin
                        state_next = ST_MARK;
                    end
                    else
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END, ST_GAP:
            begin
                if (adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        seg_valid    = 1'b0;
        seg.carrier  = CAR_HOLD;
        seg.mark_led = 1'b0;
        seg.duration = '0;
        seg.last     = 1'b0;
        unique case (state_reg)
            ST_MARK:
            begin
                seg_valid    = 1'b1;
                seg.mark_led = 1'b1;
                if (cfg.dfcw)
                begin
                    seg.carrier  = pat_reg[0] ? CAR_MARK : CAR_SPACE;
                    seg.duration = (qtr_w << 1) + qtr_w;
                end
                else
                begin
                    seg.carrier  = CAR_MARK;
                    seg.duration = pat_reg[0] ? dah_w : dit_w;
                end
            end
            ST_SEP:
            begin
                seg_valid    = 1'b1;
                seg.carrier  = cfg.dfcw ? CAR_OFF : CAR_SPACE;
                seg.duration = cfg.dfcw ? qtr_w : dit_w;
            end
            ST_END:
            begin
                seg_valid    = 1'b1;
                seg.last     = 1'b1;
                seg.duration = cfg.dfcw ? gap_w : (dit_w << 1);
            end
            ST_GAP:
            begin
                seg_valid = 1'b1;
                seg.last  = 1'b1;
                case (kind_reg)
                    JOB_SPACE: seg.duration = cfg.dfcw ? (qtr_w << 3) : ((dit_w << 2) + dit_w);
                    JOB_BAR:   seg.duration = cfg.dfcw ? (qtr_w << 4) : (dit_w << 2);
                    default:   seg.duration = cfg.dfcw ? (qtr_w << 2) : dit_w;
                endcase
            end
            default: seg_valid = 1'b0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_seg_next   = out_seg_reg;
        if (adv)
        begin
            out_valid_next = seg_valid;
            out_seg_next   = seg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg     <= pat_next;
        kind_reg    <= kind_next;
        out_seg_reg <= out_seg_next;
    end

    assign m_valid = out_valid_reg;
    assign m_seg   = out_seg_reg;

endmodule

// ===== rtl/morse_fskcw_dfcw_keyer.sv =====
// Morse keyer: one ASCII character in, a run of keying segments out.
// Input stream s_*: tdata carries char_code. Characters missing from the
// Morse table (other than space, '|' and '_') are accepted and dropped.
// Output stream m_*: one segment per transfer, tlast on the final segment
// of the character. A table character gives two segments per element
// (at most MAX_ELEMENTS elements) plus one closing gap, so up to 11
// segments; a gap mark gives one segment.
// Config channel cfg_*: index 0 keying mode, 1 FSK dit, 2 FSK dah,
// 3 DFCW quarter symbol, 4 DFCW character gap; other indexes are ignored.
// cfg_ready is always high; write only while the keyer is idle.
// A character passes through the job queue and the sequencer state before
// its first segment is registered in the output register.
// Throughput: one segment per cycle while m_tready is high; between characters
// the sequencer passes through its idle state to fetch from the two-entry job queue.
// Reset clears the queue, the output register and restores the default
// timing registers. When m_tready is low the output register holds its
// segment, the sequencer stalls and the queue absorbs up to two characters
// before s_tready drops.
module morse_fskcw_dfcw_keyer
    import fkd_pkg::*;
#(
    parameter int MAX_ELEMENTS = 5
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [CHAR_W-1:0]      s_tdata,   // [7:0] char_code
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] carrier, [2] mark_led, [22:3] duration
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [LEN_W-1:0]       cfg_data
);

    logic             mode_reg;
    logic [LEN_W-1:0] dit_reg;
    logic [LEN_W-1:0] dah_reg;
    logic [LEN_W-1:0] qtr_reg;
    logic [LEN_W-1:0] char_gap_reg;

    keycfg_t cfg;
    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    job_t    push_job;
    job_t    pop_job;
    seg_t    m_seg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            dit_reg      <= RST_FSK_DIT;
            dah_reg      <= RST_FSK_DAH;
            qtr_reg      <= RST_DFCW_QUARTER;
            char_gap_reg <= RST_DFCW_CHAR_GAP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEYING_MODE:   mode_reg     <= cfg_data[0];
                REG_FSK_DIT:       dit_reg      <= cfg_data;
                REG_FSK_DAH:       dah_reg      <= cfg_data;
                REG_DFCW_QUARTER:  qtr_reg      <= cfg_data;
                REG_DFCW_CHAR_GAP: char_gap_reg <= cfg_data;
                default:           mode_reg     <= mode_reg;
            endcase
        end
    end

    assign cfg.dfcw     = mode_reg;
    assign cfg.dit      = dit_reg;
    assign cfg.dah      = dah_reg;
    assign cfg.qtr      = qtr_reg;
    assign cfg.char_gap = char_gap_reg;

    fkd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tready (s_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    fkd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    fkd_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_job   (pop_job),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_seg   (m_seg),
        .m_ready (m_tready)
    );

    assign m_tdata = {1'b0, m_seg.duration, m_seg.mark_led, m_seg.carrier};
    assign m_tlast = m_seg.last;

endmodule

// ===== rtl/fkd_checker.sv =====
module fkd_checker
    import fkd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [CHAR_W-1:0]      s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [IDX_W-1:0]       cfg_index,
    input logic [LEN_W-1:0]       cfg_data
);

    logic unused_ok;
    assign unused_ok = s_tvalid ^ s_tready ^ (^s_tdata) ^ cfg_valid ^ (^cfg_index) ^ (^cfg_data);

    // hold a stalled segment
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output segment changed");

    // closing and gap segments are exactly the hold-carrier ones
    a_hold_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[1:0] == CAR_HOLD) == m_tlast))
        else $error("hold carrier and tlast disagree");

    a_hold_led_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == CAR_HOLD || m_tdata[1:0] == CAR_OFF) |-> !m_tdata[2])
        else $error("mark led lit on a gap segment");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready && !m_tdata[OUT_TDATA_W-1])
        else $error("config port stalled or pad bit set");

endmodule

bind morse_fskcw_dfcw_keyer fkd_checker u_fkd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

// ===== tb/testbench.sv =====
module testbench;
    import fkd_pkg::*;

    localparam int ELEMENT_LIMIT = 5;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 52;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 300;
    localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_LAST = 3'd7;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_MODEL,
        ROW_GAP,
        ROW_NONE
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [IDX_W-1:0]   idx;
        logic [LEN_W-1:0]   value;
        logic [CHAR_W-1:0]  ch;
        logic [DUR_W-1:0]   dur;
    } stim_row_t;

    typedef struct packed {
        carrier_t           carrier;
        logic               led;
        logic [DUR_W-1:0]   dur;
        logic               last;
    } segment_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [1:0] carrier, [2] mark_led, [22:3] duration
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [LEN_W-1:0]       cfg_data = '0;

    logic                   kmode;
    logic [LEN_W-1:0]       kdit;
    logic [LEN_W-1:0]       kdah;
    logic [LEN_W-1:0]       kqtr;
    logic [LEN_W-1:0]       kgap;

    segment_t               pending_segments[$];
    int unsigned            fault_count = 0;
    int unsigned            src_pct = 0;
    int unsigned            snk_pct = 0;
    bit                     stall_request = 1'b0;
    int unsigned            hold_left = 0;

    logic [CHAR_W-1:0] char_pool [19] = '{
        "/", "A", "B", "C", "D", "G", "L", "M", "N", "S", "T", "U", "V", "W", "7", "0",
        CH_SPACE, CH_BAR, CH_UNDER
    };

    stim_row_t dir_rows [39] = '{
        '{ROW_GAP,   REG_KEYING_MODE,   16'h0000, CH_SPACE, 20'd500},
        '{ROW_GAP,   REG_KEYING_MODE,   16'h0000, CH_BAR,   20'd400},
        '{ROW_GAP,   REG_KEYING_MODE,   16'h0000, CH_UNDER, 20'd100},
        '{ROW_NONE,  REG_KEYING_MODE,   16'h0000, 8'h00,    20'd0},
        '{ROW_NONE,  REG_KEYING_MODE,   16'h0000, 8'hFF,    20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "T",      20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "0",      20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "/",      20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "7",      20'd0},
        '{ROW_WRITE, REG_KEYING_MODE,   16'hFFFF, 8'h00,    20'd0},
        '{ROW_WRITE, REG_DFCW_QUARTER,  16'hFFFF, 8'h00,    20'd0},
        '{ROW_WRITE, REG_DFCW_CHAR_GAP, 16'h0000, 8'h00,    20'd0},
        '{ROW_GAP,   REG_KEYING_MODE,   16'h0000, CH_SPACE, 20'd524280},
        '{ROW_GAP,   REG_KEYING_MODE,   16'h0000, CH_BAR,   20'd1048560},
        '{ROW_GAP,   REG_KEYING_MODE,   16'h0000, CH_UNDER, 20'd262140},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "A",      20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "N",      20'd0},
        '{ROW_WRITE, REG_DFCW_QUARTER,  16'h0000, 8'h00,    20'd0},
        '{ROW_WRITE, REG_SPARE_FIRST,   16'hFFFF, 8'h00,    20'd0},
        '{ROW_WRITE, REG_SPARE_LAST,    16'hFFFF, 8'h00,    20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "B",      20'd0},
        '{ROW_GAP,   REG_KEYING_MODE,   16'h0000, CH_SPACE, 20'd0},
        '{ROW_WRITE, REG_KEYING_MODE,   16'hFFFE, 8'h00,    20'd0},
        '{ROW_WRITE, REG_FSK_DIT,       16'hFFFF, 8'h00,    20'd0},
        '{ROW_WRITE, REG_FSK_DAH,       16'h0000, 8'h00,    20'd0},
        '{ROW_GAP,   REG_KEYING_MODE,   16'h0000, CH_SPACE, 20'd327675},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "C",      20'd0},
        '{ROW_WRITE, REG_FSK_DIT,       16'h0000, 8'h00,    20'd0},
        '{ROW_WRITE, REG_FSK_DAH,       16'hFFFF, 8'h00,    20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "M",      20'd0},
        '{ROW_GAP,   REG_KEYING_MODE,   16'h0000, CH_BAR,   20'd0},
        '{ROW_WRITE, REG_FSK_DIT,       16'h0001, 8'h00,    20'd0},
        '{ROW_WRITE, REG_FSK_DAH,       16'h0001, 8'h00,    20'd0},
        '{ROW_WRITE, REG_KEYING_MODE,   16'h0001, 8'h00,    20'd0},
        '{ROW_WRITE, REG_DFCW_QUARTER,  16'h0001, 8'h00,    20'd0},
        '{ROW_WRITE, REG_DFCW_CHAR_GAP, 16'hFFFF, 8'h00,    20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "S",      20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "W",      20'd0},
        '{ROW_MODEL, REG_KEYING_MODE,   16'h0000, "G",      20'd0}
    };

    morse_fskcw_dfcw_keyer #(
        .MAX_ELEMENTS (ELEMENT_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [5:0] morse_code_of(input logic [CHAR_W-1:0] ch);
        case (ch)
            "/":     return 6'd41;
            "A":     return 6'd6;
            "B":     return 6'd17;
            "C":     return 6'd21;
            "D":     return 6'd9;
            "G":     return 6'd11;
            "L":     return 6'd18;
            "M":     return 6'd7;
            "N":     return 6'd5;
            "S":     return 6'd8;
            "T":     return 6'd3;
            "U":     return 6'd12;
            "V":     return 6'd24;
            "W":     return 6'd14;
            "7":     return 6'd35;
            "0":     return 6'd63;
            default: return 6'd0;
        endcase
    endfunction

    function automatic void push_segment(input carrier_t c, input logic led,
                                         input int unsigned d, input logic last);
        segment_t s;
        s.carrier = c;
        s.led = led;
        s.dur = d[DUR_W-1:0];
        s.last = last;
        pending_segments.push_back(s);
    endfunction

    function automatic void predict_keying(input logic [CHAR_W-1:0] ch);
        int unsigned dit;
        int unsigned q;
        logic [5:0] code;
        int n_el;
        dit = kdit;
        q = kqtr;
        if (ch == CH_SPACE)
        begin
            push_segment(CAR_HOLD, 1'b0, kmode ? 8 * q : 5 * dit, 1'b1);
            return;
        end
        if (ch == CH_BAR)
        begin
            push_segment(CAR_HOLD, 1'b0, kmode ? 16 * q : 4 * dit, 1'b1);
            return;
        end
        if (ch == CH_UNDER)
        begin
            push_segment(CAR_HOLD, 1'b0, kmode ? 4 * q : dit, 1'b1);
            return;
        end
        code = morse_code_of(ch);
        if (code == 6'd0)
            return;
        n_el = 0;
        while (code > 6'd1 && n_el < ELEMENT_LIMIT)
        begin
            if (kmode)
            begin
                push_segment(code[0] ? CAR_MARK : CAR_SPACE, 1'b1, 3 * q, 1'b0);
                push_segment(CAR_OFF, 1'b0, q, 1'b0);
            end
            else
            begin
                push_segment(CAR_MARK, 1'b1, code[0] ? int'(kdah) : dit, 1'b0);
                push_segment(CAR_SPACE, 1'b0, dit, 1'b0);
            end
            code = code >> 1;
            n_el++;
        end
        push_segment(CAR_HOLD, 1'b0, kmode ? int'(kgap) : 2 * dit, 1'b1);
    endfunction

    function automatic void apply_write(input logic [IDX_W-1:0] idx,
                                        input logic [LEN_W-1:0] value);
        case (idx)
            REG_KEYING_MODE:   kmode = value[0];
            REG_FSK_DIT:       kdit = value;
            REG_FSK_DAH:       kdah = value;
            REG_DFCW_QUARTER:  kqtr = value;
            REG_DFCW_CHAR_GAP: kgap = value;
            default: ;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length(input int phase,
                                                     input logic [LEN_W-1:0] min_len);
        if (phase == 0)
            return 16'hFFFF;
        if (phase == 1)
            return min_len;
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001;
            default: return LEN_W'($urandom_range(2000, 1));
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        apply_write(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch, input row_kind_t kind,
                             input logic [DUR_W-1:0] dur);
        @(negedge clk);
        while (src_pct != 0 && $urandom_range(99) < src_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        do @(posedge clk); while (!s_tready);
        case (kind)
            ROW_MODEL: predict_keying(ch);
            ROW_GAP:   push_segment(CAR_HOLD, 1'b0, dur, 1'b1);
            default: ;
        endcase
    endtask

    // drop valid, drain all expected segments, then let dropped characters clear
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                hold_left = LONG_HOLD;
                stall_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= snk_pct);
        end
    end

    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_segments.size() == 0)
            begin
                fault_count++;
                $display("%0t unexpected segment: expected none, got tdata %h tlast %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_segments.pop_front();
                if (m_tdata[1:0] != want.carrier)
                begin
                    fault_count++;
                    $display("%0t carrier: expected %0d, got %0d",
                             $time, want.carrier, m_tdata[1:0]);
                end
                if (m_tdata[2] != want.led)
                begin
                    fault_count++;
                    $display("%0t mark_led: expected %0d, got %0d",
                             $time, want.led, m_tdata[2]);
                end
                if (m_tdata[22:3] != want.dur)
                begin
                    fault_count++;
                    $display("%0t duration: expected %0d, got %0d",
                             $time, want.dur, m_tdata[22:3]);
                end
                if (m_tlast != want.last)
                begin
                    fault_count++;
                    $display("%0t last: expected %0d, got %0d",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    initial
    begin
        #1600000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        logic [CHAR_W-1:0] ch;
        logic mode;
        kmode = 1'b0;
        kdit = RST_FSK_DIT;
        kdah = RST_FSK_DAH;
        kqtr = RST_DFCW_QUARTER;
        kgap = RST_DFCW_CHAR_GAP;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            end
            else
                send_char(dir_rows[i].ch, dir_rows[i].kind, dir_rows[i].dur);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            case (phase % 4)
                0:
                begin
                    src_pct = 0;
                    snk_pct = 0;
                end
                1:
                begin
                    src_pct = 56;
                    snk_pct = 0;
                end
                2:
                begin
                    src_pct = 0;
                    snk_pct = 56;
                end
                default:
                begin
                    src_pct = 9;
                    snk_pct = 9;
                end
            endcase
            mode = (phase < 2) ? phase[0] : 1'($urandom_range(1));
            write_reg(REG_KEYING_MODE, {15'($urandom_range(16'h7FFF)), mode});
            write_reg(REG_FSK_DIT, pick_length(phase, 16'h0001));
            write_reg(REG_FSK_DAH, pick_length(phase, 16'h0001));
            write_reg(REG_DFCW_QUARTER, pick_length(phase, 16'h0001));
            write_reg(REG_DFCW_CHAR_GAP, pick_length(phase, 16'h0000));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // fill the keyer while the output is held off
                if (phase == 4 && k == 10)
                    stall_request = 1'b1;
                if ($urandom_range(99) < 80)
                    ch = char_pool[$urandom_range(18)];
                else
                    ch = CHAR_W'($urandom_range(255));
                send_char(ch, ROW_MODEL, '0);
            end
        end

        settle();
        if (fault_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
